// File: rtl/core/pihc_pkg.sv
// Shared types and constants for the payload image header checker.
`timescale 1ns / 1ps
`default_nettype none
package pihc_pkg;

    // Header layout and fixed values
    localparam int unsigned HDR_WORDS    = 10;
    localparam logic [31:0] IMG_MAGIC    = 32'h5035_3153;
    localparam logic [31:0] IMG_VERSION  = 32'd1;
    localparam logic [31:0] HDR_SIZE_VAL = 32'd10;

    // Word positions inside the header
    localparam int unsigned W_MAGIC   = 0;
    localparam int unsigned W_VERSION = 1;
    localparam int unsigned W_HSIZE   = 2;
    localparam int unsigned W_FLAGS   = 3;
    localparam int unsigned W_ENTRY   = 4;
    localparam int unsigned W_COUNT   = 5;
    localparam int unsigned W_ARG_A   = 6;
    localparam int unsigned W_ARG_B   = 7;
    localparam int unsigned W_EXPECT  = 8;
    localparam int unsigned W_CSUM    = 9;

    // Result status codes, in check order
    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_TOO_LARGE = 4'd1,
        ST_SHORT     = 4'd2,
        ST_MISALIGN  = 4'd3,
        ST_HEADER    = 4'd4,
        ST_ENTRY     = 4'd5,
        ST_COUNT     = 4'd6,
        ST_SIZE      = 4'd7,
        ST_EXPECTED  = 4'd8,
        ST_CHECKSUM  = 4'd9
    } t_status;

    // Header words and flags collected while an image streams in
    typedef struct packed {
        logic        header_good;
        logic        entry_good;
        logic [31:0] count_word;
        logic [31:0] arg_a;
        logic [31:0] arg_b;
        logic [31:0] expect_word;
        logic [31:0] stated_sum;
        logic [31:0] running_sum;
    } t_hdr;

    localparam t_hdr HDR_RESET = '{
        header_good: 1'b1,
        entry_good:  1'b1,
        count_word:  32'd0,
        arg_a:       32'd0,
        arg_b:       32'd0,
        expect_word: 32'd0,
        stated_sum:  32'd0,
        running_sum: 32'd0
    };

endpackage
`default_nettype wire

// File: rtl/core/pihc_status.sv
// Status encoder: picks the first failing check of a finished image.
`timescale 1ns / 1ps
`default_nettype none
module pihc_status #(
    parameter int unsigned MAX_PAYLOAD_WORDS = 16,
    parameter int unsigned CNT_W             = 7
) (
    input  wire logic [CNT_W-1:0] i_total,
    input  pihc_pkg::t_hdr        i_hdr,
    output pihc_pkg::t_status     o_status
);
    import pihc_pkg::*;

    localparam int unsigned MAX_IMAGE_BYTES = (HDR_WORDS + MAX_PAYLOAD_WORDS) * 4;

    logic [31:0] w_total_words;
    logic [31:0] w_size_words;
    logic [31:0] w_arg_sum;

    assign w_total_words = 32'(i_total[CNT_W-1:2]);
    assign w_size_words  = 32'(HDR_WORDS) + i_hdr.count_word;
    assign w_arg_sum     = i_hdr.arg_a + i_hdr.arg_b;

    // Report the first check that fails
    always_comb begin
        priority if (i_total > CNT_W'(MAX_IMAGE_BYTES)) begin
            o_status = ST_TOO_LARGE;
        end else if (i_total < CNT_W'(HDR_WORDS * 4)) begin
            o_status = ST_SHORT;
        end else if (i_total[1:0] != 2'd0) begin
            o_status = ST_MISALIGN;
        end else if (!i_hdr.header_good) begin
            o_status = ST_HEADER;
        end else if (!i_hdr.entry_good) begin
            o_status = ST_ENTRY;
        end else if (i_hdr.count_word == 32'd0 ||
                     i_hdr.count_word > 32'(MAX_PAYLOAD_WORDS)) begin
            o_status = ST_COUNT;
        end else if (w_size_words != w_total_words) begin
            o_status = ST_SIZE;
        end else if (w_arg_sum != i_hdr.expect_word) begin
            o_status = ST_EXPECTED;
        end else if (i_hdr.running_sum != i_hdr.stated_sum) begin
            o_status = ST_CHECKSUM;
        end else begin
            o_status = ST_OK;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/payload_image_header_checker_core.sv
// Top level: byte-stream image header checker with payload checksum.
//
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+------------------------------------
//  request | in        | i_valid / o_ready        | i_data_byte, i_last_byte
//  result  | out       | o_res_valid / i_res_ready| o_status, o_word_count, o_first_arg,
//          |           |                          | o_second_arg, o_expected_sum,
//          |           |                          | o_header_sum, o_computed_sum
//
// One byte per cycle. A request lands in the input register, and once it is processed the
// word assembler, header capture and checksum add update state; on the last byte
// the status encoder loads the result register, so a result passes through the input
// register and then the result register. Only a last byte waits, and only while the result
// register still holds an untaken result. Synchronous active-low reset returns the
// valid flags and image state to an empty image; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module payload_image_header_checker_core #(
    parameter int unsigned MAX_PAYLOAD_WORDS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_res_valid,
    input  wire logic        i_res_ready,
    output logic [3:0]       o_status,
    output logic [31:0]      o_word_count,
    output logic [31:0]      o_first_arg,
    output logic [31:0]      o_second_arg,
    output logic [31:0]      o_expected_sum,
    output logic [31:0]      o_header_sum,
    output logic [31:0]      o_computed_sum
);
    import pihc_pkg::*;

    localparam int unsigned MAX_IMAGE_BYTES = (HDR_WORDS + MAX_PAYLOAD_WORDS) * 4;
    localparam int unsigned CNT_W           = $clog2(MAX_IMAGE_BYTES + 2);
    localparam int unsigned IDX_W           = CNT_W - 2;

    // Input register
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;

    // Image state
    logic [CNT_W-1:0] r_total, n_total;
    logic [23:0]      r_partial, n_partial;
    t_hdr             r_hdr, n_hdr;

    // Result register
    logic             r_res_valid;
    t_status          r_status;
    t_hdr             r_res_hdr;

    logic             w_adv;
    logic [1:0]       w_pos;
    logic [IDX_W-1:0] w_idx;
    logic [31:0]      w_word;
    t_status          w_status;

    // Process the held byte unless it closes an image and the result slot is full and not being taken
    assign w_adv   = r_in_valid && (!r_in_last || !r_res_valid || i_res_ready);
    assign o_ready = !r_in_valid || w_adv;

    assign w_pos  = r_total[1:0];
    assign w_idx  = r_total[CNT_W-1:2];
    assign w_word = {r_in_byte, r_partial};

    // Assemble words, capture header fields, accumulate payload
    always_comb begin
        n_total   = r_total;
        n_partial = r_partial;
        n_hdr     = r_hdr;
        if (r_total < CNT_W'(MAX_IMAGE_BYTES)) begin
            n_total = r_total + CNT_W'(1);
            unique case (w_pos)
                2'd0: n_partial = {16'd0, r_in_byte};
                2'd1: n_partial = {8'd0, r_in_byte, r_partial[7:0]};
                2'd2: n_partial = {r_in_byte, r_partial[15:0]};
                2'd3: begin
                    n_partial = 24'd0;
                    unique case (w_idx)
                        IDX_W'(W_MAGIC):   if (w_word != IMG_MAGIC) n_hdr.header_good = 1'b0;
                        IDX_W'(W_VERSION): if (w_word != IMG_VERSION) n_hdr.header_good = 1'b0;
                        IDX_W'(W_HSIZE):   if (w_word != HDR_SIZE_VAL) n_hdr.header_good = 1'b0;
                        IDX_W'(W_FLAGS):   if (w_word != 32'd0) n_hdr.header_good = 1'b0;
                        IDX_W'(W_ENTRY):   n_hdr.entry_good = (w_word == 32'd0);
                        IDX_W'(W_COUNT):   n_hdr.count_word = w_word;
                        IDX_W'(W_ARG_A):   n_hdr.arg_a = w_word;
                        IDX_W'(W_ARG_B):   n_hdr.arg_b = w_word;
                        IDX_W'(W_EXPECT):  n_hdr.expect_word = w_word;
                        IDX_W'(W_CSUM):    n_hdr.stated_sum = w_word;
                        default:           n_hdr.running_sum = r_hdr.running_sum + w_word;
                    endcase
                end
                default: n_partial = r_partial;
            endcase
        end else begin
            // Saturate: oversized tail is only counted
            n_total = CNT_W'(MAX_IMAGE_BYTES + 1);
        end
    end

    pihc_status #(
        .MAX_PAYLOAD_WORDS (MAX_PAYLOAD_WORDS),
        .CNT_W             (CNT_W)
    ) u_status (
        .i_total  (n_total),
        .i_hdr    (n_hdr),
        .o_status (w_status)
    );

    // Input register: take a request whenever it is empty or the held one moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    // Image state: advance per byte, drop back to empty after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= '0;
            r_partial <= 24'd0;
            r_hdr     <= HDR_RESET;
        end else if (w_adv) begin
            if (r_in_last) begin
                r_total   <= '0;
                r_partial <= 24'd0;
                r_hdr     <= HDR_RESET;
            end else begin
                r_total   <= n_total;
                r_partial <= n_partial;
                r_hdr     <= n_hdr;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_adv && r_in_last) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
        if (w_adv && r_in_last) begin
            r_status  <= w_status;
            r_res_hdr <= n_hdr;
        end
    end

    assign o_res_valid    = r_res_valid;
    assign o_status       = r_status;
    assign o_word_count   = r_res_hdr.count_word;
    assign o_first_arg    = r_res_hdr.arg_a;
    assign o_second_arg   = r_res_hdr.arg_b;
    assign o_expected_sum = r_res_hdr.expect_word;
    assign o_header_sum   = r_res_hdr.stated_sum;
    assign o_computed_sum = r_res_hdr.running_sum;

    // Byte counter never passes its saturation value
    a_total_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CNT_W'(MAX_IMAGE_BYTES + 1))
        else $error("byte counter past saturation");

    // A processed last byte leaves an empty image behind
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_last) |=> (r_total == '0 && r_hdr == HDR_RESET))
        else $error("image state not cleared after last byte");

    // A new result only follows a processed last byte
    a_res_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !r_in_last && !r_res_valid) |=> !r_res_valid)
        else $error("result appeared without a last byte");

    // An ok status implies matching checksums
    a_ok_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_status == ST_OK) |->
        (r_res_hdr.running_sum == r_res_hdr.stated_sum))
        else $error("ok status with checksum mismatch");

endmodule
`default_nettype wire

// File: dv/pihc_result_monitor.sv
// Result checker for the image header checker: predicts each image result and compares.
`timescale 1ns / 1ps
module pihc_result_monitor #(
    parameter int unsigned MAX_PAYLOAD_WORDS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [3:0]  i_status,
    input  logic [31:0] i_word_count,
    input  logic [31:0] i_first_arg,
    input  logic [31:0] i_second_arg,
    input  logic [31:0] i_expected_sum,
    input  logic [31:0] i_header_sum,
    input  logic [31:0] i_computed_sum,
    output int          o_pending,
    output int          o_fail_count
);
    import pihc_pkg::*;

    localparam int unsigned IMAGE_MAX_BYTES = (HDR_WORDS + MAX_PAYLOAD_WORDS) * 4;

    typedef struct {
        t_status     status;
        logic [31:0] word_count;
        logic [31:0] first_arg;
        logic [31:0] second_arg;
        logic [31:0] expected_sum;
        logic [31:0] header_sum;
        logic [31:0] computed_sum;
    } t_image_result;

    // Results predicted but not yet seen on the result channel
    t_image_result image_results[$];
    t_image_result want;
    t_image_result outcome;

    // Image currently streaming in
    int unsigned byte_seen;
    int unsigned lane;
    logic [23:0] low_bytes;
    logic [31:0] word;
    logic        hdr_ok;
    logic        entry_ok;
    logic [31:0] count_w;
    logic [31:0] arg_a_w;
    logic [31:0] arg_b_w;
    logic [31:0] expect_w;
    logic [31:0] stated_w;
    logic [31:0] payload_sum;
    int          error_count;

    assign o_fail_count = error_count;

    function automatic void clear_image();
        byte_seen   = 0;
        low_bytes   = '0;
        hdr_ok      = 1'b1;
        entry_ok    = 1'b1;
        count_w     = '0;
        arg_a_w     = '0;
        arg_b_w     = '0;
        expect_w    = '0;
        stated_w    = '0;
        payload_sum = '0;
    endfunction

    task automatic log_error(input string msg);
        $display("[%0t] pihc_mon: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string field, input logic [31:0] got,
                               input logic [31:0] exp_val);
        if (got !== exp_val) begin
            log_error($sformatf("%s got %08h, want %08h", field, got, exp_val));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_image();
        end else begin
            // Compare a taken result with the oldest prediction; it is always from an older image
            if (i_res_valid && i_res_ready) begin
                if (image_results.size() == 0) begin
                    log_error("result with no image pending");
                end else begin
                    want = image_results.pop_front();
                    check_field("status", 32'(i_status), 32'(want.status));
                    check_field("word_count", i_word_count, want.word_count);
                    check_field("first_arg", i_first_arg, want.first_arg);
                    check_field("second_arg", i_second_arg, want.second_arg);
                    check_field("expected_sum", i_expected_sum, want.expected_sum);
                    check_field("header_sum", i_header_sum, want.header_sum);
                    check_field("computed_sum", i_computed_sum, want.computed_sum);
                end
            end
            // Advance the prediction on each taken request
            if (i_valid && i_ready) begin
                if (byte_seen < IMAGE_MAX_BYTES) begin
                    lane = byte_seen % 4;
                    if (lane == 0) begin
                        low_bytes = {16'h0000, i_data_byte};
                    end else if (lane == 3) begin
                        word = {i_data_byte, low_bytes};
                        case (byte_seen / 4)
                            W_MAGIC: begin
                                if (word != IMG_MAGIC) hdr_ok = 1'b0;
                            end
                            W_VERSION: begin
                                if (word != IMG_VERSION) hdr_ok = 1'b0;
                            end
                            W_HSIZE: begin
                                if (word != HDR_SIZE_VAL) hdr_ok = 1'b0;
                            end
                            W_FLAGS: begin
                                if (word != '0) hdr_ok = 1'b0;
                            end
                            W_ENTRY:  entry_ok = (word == '0);
                            W_COUNT:  count_w  = word;
                            W_ARG_A:  arg_a_w  = word;
                            W_ARG_B:  arg_b_w  = word;
                            W_EXPECT: expect_w = word;
                            W_CSUM:   stated_w = word;
                            default:  payload_sum = payload_sum + word;
                        endcase
                        low_bytes = '0;
                    end else begin
                        low_bytes[8 * lane +: 8] = i_data_byte;
                    end
                    byte_seen++;
                end else begin
                    // Past the largest image only the saturated count moves
                    byte_seen = IMAGE_MAX_BYTES + 1;
                end
                // Close the image: first failing check wins
                if (i_last_byte) begin
                    if (byte_seen > IMAGE_MAX_BYTES) begin
                        outcome.status = ST_TOO_LARGE;
                    end else if (byte_seen < HDR_WORDS * 4) begin
                        outcome.status = ST_SHORT;
                    end else if (byte_seen % 4 != 0) begin
                        outcome.status = ST_MISALIGN;
                    end else if (!hdr_ok) begin
                        outcome.status = ST_HEADER;
                    end else if (!entry_ok) begin
                        outcome.status = ST_ENTRY;
                    end else if (count_w == '0 || count_w > MAX_PAYLOAD_WORDS) begin
                        outcome.status = ST_COUNT;
                    end else if (32'(HDR_WORDS) + count_w != 32'(byte_seen / 4)) begin
                        outcome.status = ST_SIZE;
                    end else if (32'(arg_a_w + arg_b_w) != expect_w) begin
                        outcome.status = ST_EXPECTED;
                    end else if (payload_sum != stated_w) begin
                        outcome.status = ST_CHECKSUM;
                    end else begin
                        outcome.status = ST_OK;
                    end
                    outcome.word_count   = count_w;
                    outcome.first_arg    = arg_a_w;
                    outcome.second_arg   = arg_b_w;
                    outcome.expected_sum = expect_w;
                    outcome.header_sum   = stated_w;
                    outcome.computed_sum = payload_sum;
                    image_results.push_back(outcome);
                    clear_image();
                end
            end
        end
        o_pending <= image_results.size();
    end

endmodule

// File: dv/tb_top.sv
// Testbench top: clock, reset, image stimulus, result-side pressure and the verdict.
`timescale 1ns / 1ps
module tb_top;
    import pihc_pkg::*;

    localparam int unsigned MAX_WORDS       = 16;
    localparam int unsigned IMAGE_MAX_BYTES = (HDR_WORDS + MAX_WORDS) * 4;
    localparam int unsigned HOLDOFF_CYCLES  = 200;
    localparam int unsigned SETTLE_CYCLES   = 16;
    localparam int unsigned TOTAL_BYTES     = 1200;
    localparam int unsigned RANDOM_IMAGES   = 6;
    localparam int unsigned RUN_LIMIT_NS    = 2_000_000;

    // Image shapes: one good form, one form per way an image can fail, and random noise
    typedef enum int unsigned {
        KIND_GOOD,
        KIND_OVERSIZE,
        KIND_SHORT,
        KIND_MISALIGN,
        KIND_BAD_HEADER,
        KIND_BAD_ENTRY,
        KIND_BAD_COUNT,
        KIND_SIZE_OFF,
        KIND_BAD_EXPECT,
        KIND_BAD_CSUM,
        KIND_NOISE
    } t_image_kind;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic [7:0]  req_byte  = 8'h00;
    logic        req_last  = 1'b0;
    logic        res_ready = 1'b0;
    logic        dut_ready;
    logic        res_valid;
    logic [3:0]  res_status;
    logic [31:0] res_word_count;
    logic [31:0] res_first_arg;
    logic [31:0] res_second_arg;
    logic [31:0] res_expected_sum;
    logic [31:0] res_header_sum;
    logic [31:0] res_computed_sum;
    int          pending_results;
    int          fail_count;

    bit          quiet_stretch   = 1'b0;
    int unsigned holdoff_trigger = 0;
    int unsigned bytes_sent      = 0;
    logic [7:0]  img_stream[$];

    always #2 clk = ~clk;

    payload_image_header_checker_core #(
        .MAX_PAYLOAD_WORDS(MAX_WORDS)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (req_valid),
        .o_ready        (dut_ready),
        .i_data_byte    (req_byte),
        .i_last_byte    (req_last),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_status       (res_status),
        .o_word_count   (res_word_count),
        .o_first_arg    (res_first_arg),
        .o_second_arg   (res_second_arg),
        .o_expected_sum (res_expected_sum),
        .o_header_sum   (res_header_sum),
        .o_computed_sum (res_computed_sum)
    );

    pihc_result_monitor #(
        .MAX_PAYLOAD_WORDS(MAX_WORDS)
    ) mon (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (req_valid),
        .i_ready        (dut_ready),
        .i_data_byte    (req_byte),
        .i_last_byte    (req_last),
        .i_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .i_status       (res_status),
        .i_word_count   (res_word_count),
        .i_first_arg    (res_first_arg),
        .i_second_arg   (res_second_arg),
        .i_expected_sum (res_expected_sum),
        .i_header_sum   (res_header_sum),
        .i_computed_sum (res_computed_sum),
        .o_pending      (pending_results),
        .o_fail_count   (fail_count)
    );

    // Build one image of the given kind and offer it byte by byte
    task automatic run_image(input t_image_kind kind, input int unsigned n_payload,
                             input bit extreme);
        logic [31:0] hdr [HDR_WORDS];
        logic [31:0] payload[$];
        logic [31:0] word;
        logic [31:0] sum;
        int unsigned target;
        sum = '0;
        for (int unsigned i = 0; i < n_payload; i++) begin
            word = extreme ? 32'hffff_ffff : $urandom;
            payload.push_back(word);
            sum = sum + word;
        end
        hdr[W_MAGIC]   = IMG_MAGIC;
        hdr[W_VERSION] = IMG_VERSION;
        hdr[W_HSIZE]   = HDR_SIZE_VAL;
        hdr[W_FLAGS]   = '0;
        hdr[W_ENTRY]   = '0;
        hdr[W_COUNT]   = n_payload;
        hdr[W_ARG_A]   = extreme ? 32'hffff_ffff : $urandom;
        hdr[W_ARG_B]   = extreme ? 32'hffff_ffff : $urandom;
        hdr[W_EXPECT]  = hdr[W_ARG_A] + hdr[W_ARG_B];
        hdr[W_CSUM]    = sum;
        // Break one header word for the header-level faults
        case (kind)
            KIND_BAD_HEADER: begin
                target = $urandom_range(W_FLAGS, W_MAGIC);
                hdr[target] = hdr[target] ^ (32'd1 << $urandom_range(31));
            end
            KIND_BAD_ENTRY: begin
                hdr[W_ENTRY] = $urandom | (32'd1 << $urandom_range(31));
            end
            KIND_BAD_COUNT: begin
                case ($urandom_range(3))
                    0:       hdr[W_COUNT] = '0;
                    1:       hdr[W_COUNT] = MAX_WORDS + 1;
                    2:       hdr[W_COUNT] = 32'hffff_ffff;
                    default: hdr[W_COUNT] = MAX_WORDS + 1 + ($urandom >> 1);
                endcase
            end
            KIND_SIZE_OFF: begin
                hdr[W_COUNT] = (n_payload + $urandom_range(MAX_WORDS - 2)) % MAX_WORDS + 1;
            end
            KIND_BAD_EXPECT: begin
                hdr[W_EXPECT] = hdr[W_EXPECT] ^ (32'd1 << $urandom_range(31));
            end
            KIND_BAD_CSUM: begin
                hdr[W_CSUM] = hdr[W_CSUM] ^ (32'd1 << $urandom_range(31));
            end
            default: begin
            end
        endcase
        // Lay the words out little-endian
        img_stream.delete();
        foreach (hdr[i]) begin
            for (int k = 0; k < 4; k++) begin
                img_stream.push_back(hdr[i][8 * k +: 8]);
            end
        end
        foreach (payload[i]) begin
            for (int k = 0; k < 4; k++) begin
                img_stream.push_back(payload[i][8 * k +: 8]);
            end
        end
        // Reshape the length for the length-level faults
        case (kind)
            KIND_SHORT: begin
                target = extreme ? 1 : $urandom_range(1, HDR_WORDS * 4 - 1);
                while (img_stream.size() > target) begin
                    void'(img_stream.pop_back());
                end
            end
            KIND_OVERSIZE: begin
                target = IMAGE_MAX_BYTES + (extreme ? 1 : $urandom_range(1, 40));
                while (img_stream.size() < target) begin
                    img_stream.push_back(8'($urandom));
                end
            end
            KIND_MISALIGN: begin
                if (img_stream.size() < IMAGE_MAX_BYTES && $urandom_range(1) == 1) begin
                    repeat ($urandom_range(1, 3)) img_stream.push_back(8'($urandom));
                end else begin
                    repeat ($urandom_range(1, 3)) void'(img_stream.pop_back());
                end
            end
            KIND_NOISE: begin
                img_stream.delete();
                repeat ($urandom_range(1, IMAGE_MAX_BYTES + 36)) begin
                    img_stream.push_back(8'($urandom));
                end
            end
            default: begin
            end
        endcase
        // Offer each byte, idling at random between requests
        foreach (img_stream[i]) begin
            if (!quiet_stretch && $urandom_range(99) < 27) begin
                req_valid <= 1'b0;
                do begin
                    @(posedge clk);
                end while ($urandom_range(99) < 27);
            end
            req_valid <= 1'b1;
            req_byte  <= img_stream[i];
            req_last  <= (i == img_stream.size() - 1);
            do begin
                @(posedge clk);
            end while (!dut_ready);
            bytes_sent++;
        end
    endtask

    // Drop valid and hold until every predicted result has been taken
    task automatic wait_all_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) begin
            @(posedge clk);
        end
    endtask

    // Result side: random stalls, quiet stretches and counted hold-offs
    initial begin
        int unsigned seen_trigger;
        int unsigned hold_left;
        seen_trigger = 0;
        hold_left    = 0;
        forever begin
            @(posedge clk);
            if (holdoff_trigger != seen_trigger) begin
                seen_trigger = holdoff_trigger;
                hold_left    = HOLDOFF_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                res_ready <= 1'b0;
            end else begin
                res_ready <= quiet_stretch || ($urandom_range(99) >= 27);
            end
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("tb_top: errors");
        $finish;
    end

    initial begin
        t_image_kind kind;
        int unsigned n_images;
        int unsigned n_payload;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: size extremes, one-byte image, all-ones fields, each fault at least once
        run_image(KIND_GOOD, 1, 1'b0);
        run_image(KIND_GOOD, MAX_WORDS, 1'b1);
        run_image(KIND_SHORT, 1, 1'b1);
        run_image(KIND_SHORT, 3, 1'b0);
        run_image(KIND_OVERSIZE, MAX_WORDS, 1'b1);
        run_image(KIND_OVERSIZE, 2, 1'b0);
        for (int k = KIND_MISALIGN; k <= KIND_NOISE; k++) begin
            run_image(t_image_kind'(k), 2, 1'b0);
        end
        wait_all_results();

        // Hold off the result side while one-byte images pile up behind it
        holdoff_trigger++;
        repeat (6) run_image(KIND_SHORT, 1, 1'b1);
        run_image(KIND_GOOD, 3, 1'b0);
        wait_all_results();

        // Random images, about half well formed and mostly small, up to the byte budget
        n_images = 0;
        while (bytes_sent < TOTAL_BYTES || n_images < RANDOM_IMAGES) begin
            quiet_stretch = (n_images >= 1 && n_images < 4);
            kind = ($urandom_range(1) == 1) ? KIND_GOOD
                 : t_image_kind'($urandom_range(KIND_OVERSIZE, KIND_NOISE));
            n_payload = ($urandom_range(7) == 0) ? $urandom_range(1, MAX_WORDS)
                      : $urandom_range(1, 4);
            run_image(kind, n_payload, $urandom_range(15) == 0);
            if (n_images == 4) begin
                holdoff_trigger++;
            end
            if (n_images == 5) begin
                wait_all_results();
            end
            n_images++;
        end
        quiet_stretch = 1'b0;
        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
